@@ hw/rtl/first_fit_page_allocator_assert.svh @@
// Assertion macros shared by the first-fit page allocator RTL.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define FFPA_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define FFPA_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/ffpa_pkg.sv @@
// Shared types and constants of the first-fit page allocator.
`timescale 1ns / 1ps
package ffpa_pkg;
    localparam int ADDR_W   = 32;
    localparam int BYTES_W  = 23;
    localparam int TOTAL_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0040_0000;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK           = 2'd0;
    localparam status_t ST_NO_SPACE     = 2'd1;
    localparam status_t ST_OUT_OF_RANGE = 2'd2;
    localparam status_t ST_ZERO_SIZE    = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
endpackage

@@ hw/rtl/first_fit_page_allocator.sv @@
// Top level of the first-fit page allocator: sequencer over a rotating page map.
//
//  channel | signals                                   | direction
//  in      | in_valid in_ready op request_bytes free_address | request beats
//  out     | out_valid out_ready granted_address page_total status | result beats
//  cfg     | cfg_valid cfg_ready cfg_data              | base address writes
//
// An error found at acceptance is answered without rotating the map. A free
// rotates the map once. An allocation rotates it once to search and, on
// success, once more to mark.
// Reset clears every page entry at once. A new request is taken only when idle
// and the result register is empty; out_ready low holds the result.
`timescale 1ns / 1ps
module first_fit_page_allocator #(
    parameter int PAGE_COUNT = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffpa_pkg::ADDR_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            op,
    input  logic [ffpa_pkg::BYTES_W-1:0]    request_bytes,
    input  logic [ffpa_pkg::ADDR_W-1:0]     free_address,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ffpa_pkg::ADDR_W-1:0]     granted_address,
    output logic [ffpa_pkg::TOTAL_W-1:0]    page_total,
    output logic [ffpa_pkg::STATUS_W-1:0]   status
);
    import ffpa_pkg::*;

    localparam int W  = $clog2(PAGE_COUNT + 1);
    localparam int NW = BYTES_W + 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MARK, S_FREE} state_t;

    state_t              state_reg;
    logic [ADDR_W-1:0]   base_reg;
    logic [W-1:0]        pos_reg, start_reg, run_reg, need_reg, idx_reg, rem_reg, cnt_reg;
    logic                found_reg;
    logic                out_valid_reg;
    logic [ADDR_W-1:0]   granted_reg;
    logic [TOTAL_W-1:0]  total_reg;
    status_t             status_reg;

    logic [W-1:0] cell_q [PAGE_COUNT];
    logic [W-1:0] head, tail_in;
    logic         shift;

    logic [W-1:0] start_next, run_next, rem_next, cnt_next, eff_rem, off;
    logic         found_next, last, in_mark;
    logic [NW-1:0]     need_full;
    logic [ADDR_W-1:0] diff, idx_full, grant_addr;

    assign head  = cell_q[0];
    assign shift = (state_reg != S_IDLE);
    assign last  = (pos_reg == W'(PAGE_COUNT - 1));

    genvar g;
    generate
        for (g = 0; g < PAGE_COUNT; g++)
        begin : g_cell
            if (g == PAGE_COUNT - 1)
            begin : g_tail
                ffpa_cell #(.W(W)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift), .din(tail_in), .q(cell_q[g])
                );
            end
            else
            begin : g_body
                ffpa_cell #(.W(W)) u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift), .din(cell_q[g+1]), .q(cell_q[g])
                );
            end
        end
    endgenerate

    assign need_full = (NW'(request_bytes) + NW'((1 << PAGE_SHIFT) - 1)) >> PAGE_SHIFT;
    assign diff      = free_address - base_reg;
    assign idx_full  = diff >> PAGE_SHIFT;
    assign off       = pos_reg - start_reg;
    assign in_mark   = (pos_reg >= start_reg) && (off < need_reg);
    assign eff_rem   = (pos_reg == idx_reg) ? head : rem_reg;
    assign grant_addr = base_reg + (ADDR_W'(start_reg) << PAGE_SHIFT);

    always_comb
    begin
        start_next = start_reg;
        run_next   = run_reg;
        found_next = found_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        tail_in    = head;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    run_next   = '0;
                    found_next = 1'b0;
                    rem_next   = '0;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (!found_reg)
                begin
                    if (head != '0)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        start_next = (run_reg == '0) ? pos_reg : start_reg;
                        run_next   = run_reg + W'(1);
                        if (run_next == need_reg)
                        begin
                            found_next = 1'b1;
                        end
                    end
                end
            end
            S_MARK:
            begin
                if (pos_reg == start_reg)
                begin
                    tail_in = need_reg;
                end
                else if (in_mark)
                begin
                    tail_in = W'(1);
                end
            end
            S_FREE:
            begin
                if (eff_rem != '0)
                begin
                    tail_in  = '0;
                    rem_next = eff_rem - W'(1);
                    cnt_next = cnt_reg + W'(1);
                end
                else
                begin
                    rem_next = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= BASE_RESET;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            start_reg <= start_next;
            run_reg   <= run_next;
            found_reg <= found_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            if (shift)
            begin
                pos_reg <= last ? '0 : pos_reg + W'(1);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        granted_reg <= '0;
                        total_reg   <= '0;
                        if (op == OP_ALLOC)
                        begin
                            need_reg <= W'(need_full);
                            if (need_full == '0)
                            begin
                                status_reg    <= ST_ZERO_SIZE;
                                out_valid_reg <= 1'b1;
                            end
                            else if (need_full > NW'(PAGE_COUNT))
                            begin
                                status_reg    <= ST_NO_SPACE;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        else
                        begin
                            idx_reg <= W'(idx_full);
                            if (free_address < base_reg || idx_full >= ADDR_W'(PAGE_COUNT))
                            begin
                                status_reg    <= ST_OUT_OF_RANGE;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_FREE;
                            end
                        end
                    end
                end
                S_SCAN:
                begin
                    if (last)
                    begin
                        if (found_next)
                        begin
                            state_reg <= S_MARK;
                        end
                        else
                        begin
                            status_reg    <= ST_NO_SPACE;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_MARK:
                begin
                    if (last)
                    begin
                        granted_reg   <= grant_addr;
                        total_reg     <= TOTAL_W'(need_reg);
                        status_reg    <= ST_OK;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_FREE:
                begin
                    if (last)
                    begin
                        total_reg     <= TOTAL_W'(cnt_next);
                        status_reg    <= ST_OK;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign cfg_ready       = 1'b1;
    assign in_ready        = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid       = out_valid_reg;
    assign granted_address = granted_reg;
    assign page_total      = total_reg;
    assign status          = status_reg;

`include "first_fit_page_allocator_assert.svh"

    `FFPA_CHECK(a_ready_excl, !(in_ready && out_valid), "request taken while result pending")
    `FFPA_IMPLY(a_err_zero, out_valid && status != ST_OK,
        granted_address == '0 && page_total == '0, "error result carries data")
    `FFPA_IMPLY(a_mark_found, state_reg == S_MARK, found_reg, "marking without a found run")
endmodule

@@ hw/rtl/ffpa_cell.sv @@
// One page map entry in the rotating chain of cells.
`timescale 1ns / 1ps
module ffpa_cell #(
    parameter int W = 11
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         shift,
    input  logic [W-1:0] din,
    output logic [W-1:0] q
);
    logic [W-1:0] entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else if (shift)
        begin
            entry_reg <= din;
        end
    end

    assign q = entry_reg;
endmodule

@@ bench/ffpa_checker.sv @@
// Checker for the first-fit page allocator: predicts every result beat and compares it.
`timescale 1ns / 1ps
module ffpa_checker
    import ffpa_pkg::*;
#(
    parameter int PAGE_COUNT = 1024,
    parameter int PAGE_SHIFT = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [ADDR_W-1:0]   cfg_data,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                op,
    input  logic [BYTES_W-1:0]  request_bytes,
    input  logic [ADDR_W-1:0]   free_address,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [ADDR_W-1:0]   granted_address,
    input  logic [TOTAL_W-1:0]  page_total,
    input  logic [STATUS_W-1:0] status,
    output int                  fail_count,
    output int                  pending
);
    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [TOTAL_W-1:0] total;
        status_t            st;
    } grant_t;

    logic [TOTAL_W-1:0] page_lengths [PAGE_COUNT];
    logic [ADDR_W-1:0]  region_base;
    grant_t             awaited_grants [$];
    grant_t             want;

    function automatic grant_t allocate_run(input logic [BYTES_W-1:0] bytes);
        grant_t     g;
        longint     need;
        int         first;
        int         run;
        logic [63:0] sum;
        g = '0;
        need = (longint'(bytes) + (64'd1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
        first = 0;
        run = 0;
        if (need == 0) begin
            g.st = ST_ZERO_SIZE;
            return g;
        end
        g.st = ST_NO_SPACE;
        if (need > PAGE_COUNT)
            return g;
        for (int i = 0; i < PAGE_COUNT; i++) begin
            if (page_lengths[i] != 0) begin
                run = 0;
            end
            else begin
                if (run == 0)
                    first = i;
                run++;
                if (run == need) begin
                    page_lengths[first] = TOTAL_W'(run);
                    for (int k = 1; k < run; k++)
                        page_lengths[first + k] = 1;
                    sum = 64'(region_base) + (64'(first) << PAGE_SHIFT);
                    g.addr = sum[ADDR_W-1:0];
                    g.total = TOTAL_W'(run);
                    g.st = ST_OK;
                    return g;
                end
            end
        end
        return g;
    endfunction

    function automatic grant_t release_run(input logic [ADDR_W-1:0] addr);
        grant_t  g;
        longint  idx;
        longint  len;
        g = '0;
        if (addr < region_base) begin
            g.st = ST_OUT_OF_RANGE;
            return g;
        end
        idx = (longint'(addr) - longint'(region_base)) >>> PAGE_SHIFT;
        if (idx >= PAGE_COUNT) begin
            g.st = ST_OUT_OF_RANGE;
            return g;
        end
        len = page_lengths[idx];
        if (len > PAGE_COUNT - idx)
            len = PAGE_COUNT - idx;
        for (longint k = 0; k < len; k++)
            page_lengths[idx + k] = 0;
        g.total = TOTAL_W'(len);
        g.st = ST_OK;
        return g;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < PAGE_COUNT; i++)
                page_lengths[i] = 0;
            region_base = BASE_RESET;
            awaited_grants.delete();
            fail_count <= 0;
            pending <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                region_base = cfg_data;
            if (in_valid && in_ready) begin
                if (op == OP_ALLOC)
                    awaited_grants.push_back(allocate_run(request_bytes));
                else
                    awaited_grants.push_back(release_run(free_address));
            end
            if (out_valid && out_ready) begin
                if (awaited_grants.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result beat: addr %h total %0d status %0d",
                                 granted_address, page_total, status);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = awaited_grants.pop_front();
                    if (want.addr !== granted_address || want.total !== page_total
                        || want.st !== status) begin
                        if (fail_count < 10)
                            $display("mismatch: expected addr %h total %0d status %0d, got addr %h total %0d status %0d",
                                     want.addr, want.total, want.st,
                                     granted_address, page_total, status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= awaited_grants.size();
        end
    end
endmodule

@@ bench/first_fit_page_allocator_test.sv @@
// Testbench top of the first-fit page allocator: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module first_fit_page_allocator_test;
    import ffpa_pkg::*;

    localparam int PAGES = 1024;
    localparam int SHIFT = 12;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ADDR_W-1:0]   cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                op = OP_ALLOC;
    logic [BYTES_W-1:0]  request_bytes = '0;
    logic [ADDR_W-1:0]   free_address = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ADDR_W-1:0]   granted_address;
    logic [TOTAL_W-1:0]  page_total;
    logic [STATUS_W-1:0] status;
    int                  fail_count;
    int                  pending;

    logic                hold_req = 1'b0;
    logic                hold_done = 1'b0;
    int                  stall_left = 0;
    int                  idle_cycles = 0;
    logic [ADDR_W-1:0]   live_runs [$];
    logic [ADDR_W-1:0]   cur_base = BASE_RESET;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    first_fit_page_allocator #(.PAGE_COUNT(PAGES), .PAGE_SHIFT(SHIFT)) dut (.*);

    ffpa_checker #(.PAGE_COUNT(PAGES), .PAGE_SHIFT(SHIFT)) checker_i (.*);

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(3, 1);
        return $urandom_range(200, 20);
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                stall_left <= 3000;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(99) < 25) begin
                stall_left <= pick_gap();
                out_ready <= 1'b0;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (out_valid && out_ready && status == ST_OK && page_total != 0
            && granted_address != 0)
            live_runs.push_back(granted_address);
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic o, input logic [BYTES_W-1:0] b,
                                input logic [ADDR_W-1:0] a);
        int g;
        in_valid <= 1'b1;
        op <= o;
        request_bytes <= b;
        free_address <= a;
        do @(posedge clk); while (!in_ready);
        g = pick_gap();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic write_base(input logic [ADDR_W-1:0] v);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_base = v;
        live_runs.delete();
    endtask

    task automatic random_item();
        int r;
        int k;
        logic [BYTES_W-1:0] b;
        logic [ADDR_W-1:0]  a;
        r = $urandom_range(99);
        if (r < 50) begin
            if ($urandom_range(19) == 0)
                b = BYTES_W'($urandom);
            else
                b = BYTES_W'($urandom_range(32768));
            send_request(OP_ALLOC, b, ADDR_W'($urandom));
        end
        else begin
            r = $urandom_range(99);
            if (r < 60 && live_runs.size() > 0) begin
                k = $urandom_range(live_runs.size() - 1);
                a = live_runs[k];
                live_runs.delete(k);
            end
            else if (r < 85) begin
                a = cur_base + (ADDR_W'($urandom_range(PAGES - 1)) << SHIFT)
                    + ADDR_W'($urandom_range(4095));
            end
            else begin
                a = $urandom;
            end
            send_request(OP_FREE, BYTES_W'($urandom), a);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] bases [5];
        bases[0] = '0;
        bases[1] = 32'hFFFF_F000;
        bases[2] = $urandom;
        bases[3] = 32'hFFFF_FFFF;
        bases[4] = BASE_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_ALLOC, 23'd0, '0);
        send_request(OP_ALLOC, 23'd4194305, '0);
        send_request(OP_ALLOC, 23'h7FFFFF, 32'hFFFF_FFFF);
        send_request(OP_ALLOC, 23'd4194304, '0);
        send_request(OP_ALLOC, 23'd1, '0);
        send_request(OP_FREE, '0, BASE_RESET);
        send_request(OP_ALLOC, 23'd1, '0);
        send_request(OP_ALLOC, 23'd4096, '0);
        send_request(OP_ALLOC, 23'd4097, '0);
        send_request(OP_FREE, '0, BASE_RESET + 32'h0000_3000);
        send_request(OP_FREE, '0, BASE_RESET + 32'h0000_2FFF);
        send_request(OP_FREE, '0, BASE_RESET + 32'h0000_2000);
        send_request(OP_FREE, '0, BASE_RESET + 32'h0010_0000);
        send_request(OP_FREE, '0, BASE_RESET - 32'd1);
        send_request(OP_FREE, '0, 32'h0000_0000);
        send_request(OP_FREE, '0, 32'hFFFF_FFFF);
        send_request(OP_FREE, 23'h7FFFFF, BASE_RESET);
        send_request(OP_FREE, '0, BASE_RESET + 32'h0000_1000);
        send_request(OP_ALLOC, 23'd4194304, '0);
        send_request(OP_FREE, '0, BASE_RESET + 32'h000F_F000);

        for (int p = 0; p < 5; p++) begin
            write_base(bases[p]);
            for (int n = 0; n < 112; n++) begin
                if (p == 1 && n == 40)
                    hold_req <= 1'b1;
                random_item();
            end
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ffpa_pkg.sv
hw/rtl/ffpa_cell.sv
hw/rtl/first_fit_page_allocator.sv
bench/ffpa_checker.sv
bench/first_fit_page_allocator_test.sv
